// ----- design/lfbt_pkg.sv -----
// Package for the LED flash and beep timer: payload structs, command codes,
// register indexes and reset constants. No dependencies.
`default_nettype none

package lfbt_pkg;

  localparam int LFBT_NUM_LEDS = 2;

  localparam int TICKS_W   = 16;
  localparam int FLASH_W   = 8;
  localparam int DIV_W     = 8;
  localparam int REG_IDX_W = 2;

  localparam logic [DIV_W-1:0]   BEEP_DIVIDER_RST = DIV_W'(1);
  localparam logic [TICKS_W-1:0] SHORT_BEEP_RST   = TICKS_W'(60);
  localparam logic [TICKS_W-1:0] LONG_BEEP_RST    = TICKS_W'(200);

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SHORT_BEEP = 2'd1,
    CMD_LONG_BEEP  = 2'd2,
    CMD_FLASH      = 2'd3
  } lfbt_cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BEEP_DIVIDER = 2'd0,
    REG_SHORT_BEEP   = 2'd1,
    REG_LONG_BEEP    = 2'd2
  } lfbt_reg_t;

  typedef struct packed {
    lfbt_cmd_t            cmd;
    logic                 led_index;
    logic [TICKS_W-1:0]   on_ticks;
    logic [FLASH_W-1:0]   flash_total;
    logic [TICKS_W-1:0]   gap_ticks;
  } lfbt_in_t;

  typedef struct packed {
    logic [1:0] led_levels;
    logic       beep_level;
    logic [1:0] led_busy;
    logic       beep_active;
  } lfbt_out_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [TICKS_W-1:0]   wdata;
  } lfbt_cfg_t;

  // Per-LED strobes from the command decode.
  typedef struct packed {
    logic tick;
    logic start;
  } lfbt_led_ctl_t;

  // Per-LED status after the current beat is applied.
  typedef struct packed {
    logic pin;
    logic busy;
  } lfbt_led_stat_t;

endpackage

`default_nettype wire

// ----- design/lfbt_chan_if.sv -----
// Valid/ready channel carrying one payload beat of type T.
// Used for command input, result output and register writes; T is set to lfbt_pkg types.
`default_nettype none

interface lfbt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lfbt_led_seq.sv -----
// Flash sequencer for one LED: on-time, flash count and gap counters.
// Depends on lfbt_pkg.
`default_nettype none

module lfbt_led_seq
  import lfbt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire lfbt_led_ctl_t        ctl,
  input  wire logic [TICKS_W-1:0]   on_ticks,
  input  wire logic [FLASH_W-1:0]   flash_total,
  input  wire logic [TICKS_W-1:0]   gap_ticks,
  output lfbt_led_stat_t            stat_next
);

  logic [TICKS_W-1:0] on_counter, on_counter_next;
  logic [TICKS_W-1:0] on_reload, on_reload_next;
  logic [FLASH_W-1:0] flashes_left, flashes_left_next;
  logic [TICKS_W-1:0] gap_counter, gap_counter_next;
  logic [TICKS_W-1:0] gap_reload, gap_reload_next;
  logic               led_pin, led_pin_next;
  logic               busy_flag, busy_flag_next;

  always_comb begin
    on_counter_next   = on_counter;
    on_reload_next    = on_reload;
    flashes_left_next = flashes_left;
    gap_counter_next  = gap_counter;
    gap_reload_next   = gap_reload;
    led_pin_next      = led_pin;
    busy_flag_next    = busy_flag;

    if (ctl.start) begin
      // restart keeps a running on-time
      led_pin_next      = 1'b1;
      busy_flag_next    = 1'b1;
      flashes_left_next = flash_total;
      on_reload_next    = on_ticks;
      if (on_counter == '0) begin
        on_counter_next = on_ticks;
      end
      gap_counter_next  = '0;
      gap_reload_next   = (gap_ticks == '0) ? TICKS_W'(1) : gap_ticks;
    end else if (ctl.tick) begin
      if (on_counter != '0) begin
        on_counter_next = on_counter - TICKS_W'(1);
        if (on_counter_next == '0 && flashes_left != '0) begin
          led_pin_next      = 1'b0;
          flashes_left_next = flashes_left - FLASH_W'(1);
          if (flashes_left_next == '0) begin
            busy_flag_next   = 1'b0;
            gap_counter_next = '0;
          end else begin
            gap_counter_next = gap_reload;
          end
        end
      end else if (gap_counter != '0) begin
        gap_counter_next = gap_counter - TICKS_W'(1);
        if (gap_counter_next == '0) begin
          on_counter_next = on_reload;
          led_pin_next    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_counter   <= '0;
      flashes_left <= '0;
      gap_counter  <= '0;
      led_pin      <= 1'b0;
      busy_flag    <= 1'b0;
    end else if (en) begin
      on_counter   <= on_counter_next;
      flashes_left <= flashes_left_next;
      gap_counter  <= gap_counter_next;
      led_pin      <= led_pin_next;
      busy_flag    <= busy_flag_next;
    end
  end

  // reload values are only read after a start has written them
  always_ff @(posedge clk) begin
    if (en) begin
      on_reload  <= on_reload_next;
      gap_reload <= gap_reload_next;
    end
  end

  assign stat_next.pin  = led_pin_next;
  assign stat_next.busy = busy_flag_next;

endmodule

`default_nettype wire

// ----- design/led_flash_and_beep_timer_unit.sv -----
// LED flash and beep timer, top level. Depends on lfbt_pkg, lfbt_chan_if, lfbt_led_seq.
// The result beat is registered in the cycle after its command beat is accepted.
// Throughput: one command beat per cycle; the result register frees itself
// whenever the sink takes its beat, so input stalls only under output backpressure.
// Reset (rst, synchronous, active high): registers back to 1/60/200, all counters
// zero, buzzer and LEDs off, nothing busy, no result pending.
`default_nettype none

module led_flash_and_beep_timer_unit
  import lfbt_pkg::*;
#(
  parameter int NUM_LEDS = LFBT_NUM_LEDS
)(
  input  wire logic  clk,
  input  wire logic  rst,
  lfbt_chan_if.sink   in_ch,
  lfbt_chan_if.source out_ch,
  lfbt_chan_if.sink   cfg
);

  // LEDs visible in the 2-bit output fields
  localparam int SHOWN = (NUM_LEDS < 2) ? NUM_LEDS : 2;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an unknown index is a no-op.
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]   beep_divider;
  logic [TICKS_W-1:0] short_beep_ticks;
  logic [TICKS_W-1:0] long_beep_ticks;
  lfbt_cfg_t          cfg_beat;

  assign cfg.ready = 1'b1;
  assign cfg_beat  = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      beep_divider     <= BEEP_DIVIDER_RST;
      short_beep_ticks <= SHORT_BEEP_RST;
      long_beep_ticks  <= LONG_BEEP_RST;
    end else if (cfg.valid) begin
      unique case (cfg_beat.reg_index)
        REG_BEEP_DIVIDER: beep_divider     <= cfg_beat.wdata[DIV_W-1:0];
        REG_SHORT_BEEP:   short_beep_ticks <= cfg_beat.wdata;
        REG_LONG_BEEP:    long_beep_ticks  <= cfg_beat.wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: a command beat is taken whenever the result register is empty
  // or being drained in the same cycle.
  // ---------------------------------------------------------------------------
  logic      out_valid;
  lfbt_out_t out_data;
  logic      accept;
  lfbt_in_t  beat;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign beat         = in_ch.data;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  logic               is_tick;
  logic               is_beep;
  logic               is_flash;
  logic [TICKS_W-1:0] beep_load;

  always_comb begin
    is_tick   = 1'b0;
    is_beep   = 1'b0;
    is_flash  = 1'b0;
    beep_load = short_beep_ticks;
    unique case (beat.cmd)
      CMD_TICK:       is_tick = 1'b1;
      CMD_SHORT_BEEP: is_beep = 1'b1;
      CMD_LONG_BEEP: begin
        is_beep   = 1'b1;
        beep_load = long_beep_ticks;
      end
      CMD_FLASH:      is_flash = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Buzzer: prescaler toggles the pin while the timeout runs; the pin is
  // forced off when the timeout reaches zero or a zero timeout is loaded.
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]   beep_prescale, beep_prescale_next, prescale_inc;
  logic [TICKS_W-1:0] beep_remaining, beep_remaining_next;
  logic               buzzer_pin, buzzer_pin_next;

  always_comb begin
    beep_prescale_next  = beep_prescale;
    beep_remaining_next = beep_remaining;
    buzzer_pin_next     = buzzer_pin;
    prescale_inc        = beep_prescale + DIV_W'(1);

    if (is_tick) begin
      // divider of 0 or 1 wraps on every tick
      if (prescale_inc >= beep_divider) begin
        beep_prescale_next = '0;
        if (beep_remaining != '0) begin
          buzzer_pin_next = !buzzer_pin;
        end
      end else begin
        beep_prescale_next = prescale_inc;
      end
      if (beep_remaining != '0) begin
        beep_remaining_next = beep_remaining - TICKS_W'(1);
        if (beep_remaining_next == '0) begin
          buzzer_pin_next = 1'b0;
        end
      end
    end else if (is_beep) begin
      beep_remaining_next = beep_load;
      if (beep_load == '0) begin
        buzzer_pin_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beep_prescale  <= '0;
      beep_remaining <= '0;
      buzzer_pin     <= 1'b0;
    end else if (accept) begin
      beep_prescale  <= beep_prescale_next;
      beep_remaining <= beep_remaining_next;
      buzzer_pin     <= buzzer_pin_next;
    end
  end

  // ---------------------------------------------------------------------------
  // LED sequencers. A flash with zero on-time or zero count is dropped; an
  // index past NUM_LEDS matches no sequencer.
  // ---------------------------------------------------------------------------
  logic           flash_ok;
  lfbt_led_stat_t led_stat [NUM_LEDS];

  assign flash_ok = is_flash && (beat.on_ticks != '0) && (beat.flash_total != '0);

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    lfbt_led_ctl_t ctl;

    assign ctl.tick  = is_tick;
    assign ctl.start = flash_ok && (32'(beat.led_index) == i);

    lfbt_led_seq u_seq (
      .clk         (clk),
      .rst         (rst),
      .en          (accept),
      .ctl         (ctl),
      .on_ticks    (beat.on_ticks),
      .flash_total (beat.flash_total),
      .gap_ticks   (beat.gap_ticks),
      .stat_next   (led_stat[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register: status after the beat is applied.
  // ---------------------------------------------------------------------------
  lfbt_out_t result;

  always_comb begin
    result             = '0;
    result.beep_level  = buzzer_pin_next;
    result.beep_active = (beep_remaining_next != '0);
    for (int i = 0; i < SHOWN; i++) begin
      result.led_levels[i] = led_stat[i].pin;
      result.led_busy[i]   = led_stat[i].busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
